[hdl/ptw_pkg.sv]
package ptw_pkg;

    localparam int VA_W        = 48;
    localparam int PTE_W       = 64;
    localparam int ADDR_W      = 53;
    localparam int ROOT_W      = 52;
    localparam int IDX_W       = 9;
    localparam int ENTRY_SHIFT = 3;
    localparam int PAGE_SHIFT  = 12;
    localparam int L2_SHIFT    = 21;
    localparam int L1_SHIFT    = 30;
    localparam int L0_SHIFT    = 39;
    localparam int PRESENT_BIT = 0;
    localparam int HUGE_BIT    = 7;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 56;

    typedef enum logic {
        OP_TRANSLATE = 1'b0,
        OP_READ_RESP = 1'b1
    } op_t;

    typedef enum logic {
        KIND_READ_REQ = 1'b0,
        KIND_DONE     = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        PS_4K   = 2'd0,
        PS_2M   = 2'd1,
        PS_1G   = 2'd2,
        PS_NONE = 2'd3
    } pg_size_t;

    // level of the entry being awaited, top first
    typedef enum logic [1:0] {
        LVL_PML4 = 2'd0,
        LVL_PDPT = 2'd1,
        LVL_PD   = 2'd2,
        LVL_PT   = 2'd3
    } level_t;

    typedef struct packed {
        op_t              opcode;
        logic [VA_W-1:0]  vaddr;
        logic [PTE_W-1:0] read_data;
    } in_item_t;

    typedef struct packed {
        kind_t             kind;
        logic [ADDR_W-1:0] address;
        logic              mapped;
        pg_size_t          pg_size;
    } result_t;

    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                  input level_t lvl);
        logic [IDX_W-1:0] idx;
        unique case (lvl)
            LVL_PML4: idx = va[L0_SHIFT +: IDX_W];
            LVL_PDPT: idx = va[L1_SHIFT +: IDX_W];
            LVL_PD:   idx = va[L2_SHIFT +: IDX_W];
            LVL_PT:   idx = va[PAGE_SHIFT +: IDX_W];
            default:  idx = '0;
        endcase
        return idx;
    endfunction

endpackage

[hdl/four_level_page_table_walker.sv]
// Four-level page table walker, 48-bit virtual addresses.
// Input stream (s_*): tuser[0] selects a translate request (virtual address in
// tdata) or a memory read response (a 64-bit table entry in tdata). Result
// stream (m_*): tuser[0] is 0 for a read request of the entry address in tdata,
// 1 when the walk is done (translated address, mapped flag, page size).
// The memory side is closed through the caller: every read request it sees
// must come back as one response transaction. Requests during a walk and
// responses with no walk open produce no result transaction.
// Path: the input register, then decision logic into the result register that
// drives m_tvalid. Throughput: one input transaction per cycle while results
// are taken; walk state updates as each item leaves the input register, so
// back-to-back items see the state of the one before.
// Stall: when m_tready is low the result register holds, the input register
// fills, and s_tready drops until the result is taken.
// Reset (aresetn low, synchronous): both stages empty, walker idle, root
// table base cleared. Root base (CR3 equivalent) is written over APB with
// paddr[3] low and should only change while no walk is open.
module four_level_page_table_walker #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // APB config
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [3:0]                     paddr,
    input  logic [63:0]                    pwdata,
    output logic [63:0]                    prdata,
    output logic                           pready,
    // input stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptw_pkg::S_TDATA_W-1:0]  s_tdata,   // vaddr[47:0], read_data[111:48]
    input  logic [0:0]                     s_tuser,   // opcode
    // result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptw_pkg::M_TDATA_W-1:0]  m_tdata,   // address[52:0], mapped[53], pg_size[55:54]
    output logic [0:0]                     m_tuser    // result_kind
);

    logic [ptw_pkg::ROOT_W-1:0] root_reg, root_next;
    logic                       cfg_wr;

    logic                       item_valid;
    ptw_pkg::in_item_t          item;
    logic                       advance;
    logic                       out_free;
    logic                       produce;
    ptw_pkg::result_t           result;

    // ---- config port: one 52-bit register, decoded at paddr[3] low ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        root_next = root_reg;
        if (cfg_wr && !paddr[3]) begin
            root_next = pwdata[ptw_pkg::ROOT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg <= '0;
        end else begin
            root_reg <= root_next;
        end
    end

    assign prdata = paddr[3] ? 64'd0 : 64'(root_reg);

    // ---- datapath ----
    // item leaves the input register whenever the result register can take it
    assign advance = item_valid && out_free;

    ptw_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    ptw_step #(
        .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
    ) u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .item      (item),
        .root_base (root_reg[PHYS_ADDR_BITS-1:ptw_pkg::PAGE_SHIFT]),
        .produce   (produce),
        .result    (result)
    );

    ptw_out_reg u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (produce),
        .result   (result),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // ---- checks ----
    // input side only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without a stalled result");

    // unmapped finish carries zero address and size
    a_unmapped_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] && !m_tdata[53]) |->
        (m_tdata[52:0] == 53'd0 && m_tdata[55:54] == 2'd0))
        else $error("unmapped result with nonzero address or size");

    // read requests are never marked mapped, and are 8-byte aligned
    a_req_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser[0]) |->
        (!m_tdata[53] && m_tdata[55:54] == 2'd0 && m_tdata[2:0] == 3'd0))
        else $error("malformed read request");

    // no page size code outside 4K/2M/1G
    a_size_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[55:54] != 2'd3))
        else $error("illegal page size");

    // a result only appears after an item has left the input register
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(advance))
        else $error("result without a source item");

endmodule

[hdl/ptw_in_reg.sv]
module ptw_in_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptw_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [0:0]                     s_tuser,
    input  logic                           advance,
    output logic                           item_valid,
    output ptw_pkg::in_item_t              item
);

    logic              valid_reg, valid_next;
    ptw_pkg::in_item_t item_reg;

    // stage frees up in the same cycle it hands its item on
    assign s_tready = !valid_reg || advance;

    always_comb begin
        valid_next = valid_reg;
        if (s_tready) begin
            valid_next = s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.opcode    <= ptw_pkg::op_t'(s_tuser[0]);
            item_reg.vaddr     <= s_tdata[ptw_pkg::VA_W-1:0];
            item_reg.read_data <= s_tdata[ptw_pkg::VA_W +: ptw_pkg::PTE_W];
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/ptw_step.sv]
module ptw_step #(
    parameter int PHYS_ADDR_BITS = 52
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          advance,
    input  ptw_pkg::in_item_t                             item,
    input  logic [PHYS_ADDR_BITS-1:ptw_pkg::PAGE_SHIFT]   root_base,
    output logic                                          produce,
    output ptw_pkg::result_t                              result
);

    localparam int AW = ptw_pkg::ADDR_W;
    localparam int PS = ptw_pkg::PAGE_SHIFT;

    logic                        busy_reg, busy_next;
    ptw_pkg::level_t             level_reg, level_next;
    logic [ptw_pkg::VA_W-1:0]    vaddr_reg, vaddr_next;

    logic [ptw_pkg::PTE_W-1:0]   pte;
    logic                        present, huge;
    logic [PHYS_ADDR_BITS-1:PS]  next_base;
    ptw_pkg::level_t             level_inc;

    assign pte       = item.read_data;
    assign present   = pte[ptw_pkg::PRESENT_BIT];
    assign huge      = pte[ptw_pkg::HUGE_BIT];
    assign next_base = pte[PHYS_ADDR_BITS-1:PS];
    assign level_inc = ptw_pkg::level_t'(level_reg + 2'd1);

    always_comb begin
        produce    = 1'b0;
        result     = '{kind: ptw_pkg::KIND_READ_REQ, address: '0, mapped: 1'b0,
                       pg_size: ptw_pkg::PS_4K};
        busy_next  = busy_reg;
        level_next = level_reg;
        vaddr_next = vaddr_reg;
        if (advance) begin
            unique case (item.opcode)
                ptw_pkg::OP_TRANSLATE: begin
                    if (!busy_reg) begin
                        produce        = 1'b1;
                        busy_next      = 1'b1;
                        level_next     = ptw_pkg::LVL_PML4;
                        vaddr_next     = item.vaddr;
                        result.address = AW'({root_base,
                            ptw_pkg::va_index(item.vaddr, ptw_pkg::LVL_PML4),
                            3'b000});
                    end
                end
                ptw_pkg::OP_READ_RESP: begin
                    if (busy_reg) begin
                        produce = 1'b1;
                        priority if (!present) begin
                            result.kind = ptw_pkg::KIND_DONE;
                            busy_next   = 1'b0;
                            level_next  = ptw_pkg::LVL_PML4;
                        end else if (level_reg == ptw_pkg::LVL_PDPT && huge) begin
                            result.kind      = ptw_pkg::KIND_DONE;
                            result.mapped    = 1'b1;
                            result.pg_size   = ptw_pkg::PS_1G;
                            result.address   = AW'({pte[PHYS_ADDR_BITS-1:ptw_pkg::L1_SHIFT],
                                                    vaddr_reg[ptw_pkg::L1_SHIFT-1:0]});
                            busy_next        = 1'b0;
                            level_next       = ptw_pkg::LVL_PML4;
                        end else if (level_reg == ptw_pkg::LVL_PD && huge) begin
                            result.kind      = ptw_pkg::KIND_DONE;
                            result.mapped    = 1'b1;
                            result.pg_size   = ptw_pkg::PS_2M;
                            result.address   = AW'({pte[PHYS_ADDR_BITS-1:ptw_pkg::L2_SHIFT],
                                                    vaddr_reg[ptw_pkg::L2_SHIFT-1:0]});
                            busy_next        = 1'b0;
                            level_next       = ptw_pkg::LVL_PML4;
                        end else if (level_reg == ptw_pkg::LVL_PT) begin
                            result.kind      = ptw_pkg::KIND_DONE;
                            result.mapped    = 1'b1;
                            result.pg_size   = ptw_pkg::PS_4K;
                            result.address   = AW'({next_base, vaddr_reg[PS-1:0]});
                            busy_next        = 1'b0;
                            level_next       = ptw_pkg::LVL_PML4;
                        end else begin
                            // descend; top-level huge bit is ignored
                            level_next     = level_inc;
                            result.address = AW'({next_base,
                                ptw_pkg::va_index(vaddr_reg, level_inc), 3'b000});
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            level_reg <= ptw_pkg::LVL_PML4;
            vaddr_reg <= '0;
        end else begin
            busy_reg  <= busy_next;
            level_reg <= level_next;
            vaddr_reg <= vaddr_next;
        end
    end

endmodule

[hdl/ptw_out_reg.sv]
module ptw_out_reg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           load,
    input  ptw_pkg::result_t               result,
    output logic                           out_free,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptw_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic [0:0]                     m_tuser
);

    logic             valid_reg, valid_next;
    ptw_pkg::result_t res_reg;

    assign out_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        if (out_free) begin
            valid_next = load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && out_free) begin
            res_reg <= result;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.pg_size, res_reg.mapped, res_reg.address};
    assign m_tuser  = res_reg.kind;

endmodule
